[rtl/bbq_pkg.sv]
`default_nettype none

package bbq_pkg;

   // Default field widths.
   localparam int unsigned BBQ_COORD_BITS = 32;
   localparam int unsigned BBQ_QUANT_BITS = 16;

   // Number of coordinate axes: x, y and z.
   localparam int unsigned BBQ_AXES = 3;

   // The box is widened by (10*dim + maxdim) / 100 on each side.
   localparam int unsigned BBQ_WIDEN_DIV = 100;

   // Request codes.
   localparam logic [1:0] BBQ_REQ_ACCUM  = 2'd0;
   localparam logic [1:0] BBQ_REQ_FINISH = 2'd1;
   localparam logic [1:0] BBQ_REQ_QUANT  = 2'd2;

   // Result kinds.
   localparam logic BBQ_KIND_BOX   = 1'b0;
   localparam logic BBQ_KIND_QUANT = 1'b1;

   // Control of the bit-serial divider lanes.
   typedef struct packed {
      logic load;
      logic step;
   } bbq_div_ctl_type;

endpackage

`default_nettype wire

[rtl/bbq_req_if.sv]
`default_nettype none

interface bbq_req_if
   import bbq_pkg::*;
#(
   parameter int unsigned COORD_BITS = BBQ_COORD_BITS
) ();

   logic                         valid;
   logic                         ready;
   logic [1:0]                   req_type;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;
   logic [7:0]                   flag_in;
   logic [7:0]                   story_in;

   modport source (
      output valid, req_type, coord_x, coord_y, coord_z, flag_in, story_in,
      input  ready
   );

   modport sink (
      input  valid, req_type, coord_x, coord_y, coord_z, flag_in, story_in,
      output ready
   );

endinterface

`default_nettype wire

[rtl/bbq_rsp_if.sv]
`default_nettype none

interface bbq_rsp_if
   import bbq_pkg::*;
#(
   parameter int unsigned COORD_BITS = BBQ_COORD_BITS,
   parameter int unsigned QUANT_BITS = BBQ_QUANT_BITS
) ();

   logic                       valid;
   logic                       ready;
   logic                       out_kind;
   logic [1:0]                 axis;
   logic signed [COORD_BITS:0] box_low;
   logic signed [COORD_BITS:0] box_high;
   logic [QUANT_BITS-1:0]      quant_x;
   logic [QUANT_BITS-1:0]      quant_y;
   logic [QUANT_BITS-1:0]      quant_z;
   logic [7:0]                 flag_out;
   logic [7:0]                 story_out;
   logic                       last;

   modport source (
      output valid, out_kind, axis, box_low, box_high, quant_x, quant_y, quant_z,
             flag_out, story_out, last,
      input  ready
   );

   modport sink (
      input  valid, out_kind, axis, box_low, box_high, quant_x, quant_y, quant_z,
             flag_out, story_out, last,
      output ready
   );

endinterface

`default_nettype wire

[rtl/bbq_sdiv.sv]
`default_nettype none

// Restoring divider that retires one quotient bit per step. The dividend
// enters from a shift register, most significant bit first, behind an
// optional starting remainder.
module bbq_sdiv
   import bbq_pkg::*;
#(
   parameter int unsigned REM_BITS = BBQ_COORD_BITS + 2,
   parameter int unsigned NUM_BITS = BBQ_COORD_BITS + 4,
   parameter int unsigned QUO_BITS = BBQ_COORD_BITS + 4
) (
   input  wire logic                clock,
   input  wire bbq_div_ctl_type     ctl,
   input  wire logic [REM_BITS-1:0] load_rem,
   input  wire logic [NUM_BITS-1:0] load_num,
   input  wire logic [REM_BITS-1:0] divisor,
   output logic      [QUO_BITS-1:0] quotient
);

   logic [REM_BITS-1:0] rem_ff, rem_in;
   logic [NUM_BITS-1:0] num_ff, num_in;
   logic [REM_BITS-1:0] div_ff, div_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic [REM_BITS-1:0] trial;
   logic                take;

   assign trial = {rem_ff[REM_BITS-2:0], num_ff[NUM_BITS-1]};
   assign take  = (trial >= div_ff);

   always_comb begin
      rem_in = rem_ff;
      num_in = num_ff;
      div_in = div_ff;
      quo_in = quo_ff;
      if (ctl.load) begin
         rem_in = load_rem;
         num_in = load_num;
         div_in = divisor;
         quo_in = '0;
      end else if (ctl.step) begin
         rem_in = take ? (trial - div_ff) : trial;
         num_in = {num_ff[NUM_BITS-2:0], 1'b0};
         quo_in = {quo_ff[QUO_BITS-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      num_ff <= num_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/bounding_box_point_quantizer_core.sv]
// Two-pass bounding-box point quantizer. Accumulate transactions (req_type 0)
// fold a point into the running minimum and maximum of x, y and z. A finish
// transaction (req_type 1) widens every axis by
// floor((10*dim + maxdim) / 100), freezes that box and returns three box
// transactions, x, y and z in that order, the last one marked with last; it
// holds the request side through the bit-serial divide by 100 and until all
// three have entered the output register. A quantize transaction
// (req_type 2) returns one transaction carrying
// round-half-up((p - low) * 2^QUANT_BITS / (high - low)) per axis, saturated to
// 0..2^QUANT_BITS-1, together with the flag and story bytes; a flat axis or a
// point at or below the low bound gives 0. A quantize transaction occupies the
// block while the three radix-2 divider lanes produce QUANT_BITS+1 quotient
// bits, one per cycle. Request code 3 is dropped without a result. The block
// works on one request at a time, but a finished result waits in the output
// register, so the next request may be taken before the previous result has
// been collected.
`default_nettype none

module bounding_box_point_quantizer_core
   import bbq_pkg::*;
#(
   parameter int unsigned COORD_BITS = BBQ_COORD_BITS,
   parameter int unsigned QUANT_BITS = BBQ_QUANT_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   bbq_req_if.sink   req_chan,
   bbq_rsp_if.source rsp_chan
);

   // Widths. Spans and widened bounds need one bit more than a coordinate;
   // a point minus a widened bound needs two.
   localparam int unsigned CW     = COORD_BITS;
   localparam int unsigned QB     = QUANT_BITS;
   localparam int unsigned BOX_W  = CW + 1;
   localparam int unsigned DIFF_W = CW + 2;
   localparam int unsigned REM_W  = CW + 2;
   localparam int unsigned NUM_W  = CW + 4;
   localparam int unsigned QUO_W  = (NUM_W > QB + 1) ? NUM_W : QB + 1;
   localparam int unsigned STEP_W = $clog2(QUO_W + 1);
   localparam logic [1:0]  AXIS_LAST = 2'(BBQ_AXES - 1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_F_MAX,
      S_F_NUM,
      S_F_DIV,
      S_F_BOX,
      S_F_SPAN,
      S_F_EMIT,
      S_Q_CMP,
      S_Q_DIV,
      S_Q_OUT
   } state_type;

   state_type state_ff, state_in;

   // Running box and frozen box, one entry per axis.
   logic              have_point_ff, have_point_in;
   logic signed [CW-1:0] run_min_ff [BBQ_AXES];
   logic signed [CW-1:0] run_min_in [BBQ_AXES];
   logic signed [CW-1:0] run_max_ff [BBQ_AXES];
   logic signed [CW-1:0] run_max_in [BBQ_AXES];
   logic [BOX_W-1:0]  frozen_low_ff  [BBQ_AXES];
   logic [BOX_W-1:0]  frozen_low_in  [BBQ_AXES];
   logic [BOX_W-1:0]  frozen_high_ff [BBQ_AXES];
   logic [BOX_W-1:0]  frozen_high_in [BBQ_AXES];
   logic [BOX_W-1:0]  span_ff [BBQ_AXES];
   logic [BOX_W-1:0]  span_in [BBQ_AXES];

   // Working registers of the finish and quantize sequences.
   logic [CW-1:0]     dim_ff [BBQ_AXES];
   logic [CW-1:0]     dim_in [BBQ_AXES];
   logic [CW-1:0]     maxd_ff, maxd_in;
   logic [NUM_W-1:0]  ten_ff [BBQ_AXES];
   logic [NUM_W-1:0]  ten_in [BBQ_AXES];
   logic [DIFF_W-1:0] diff_ff [BBQ_AXES];
   logic [DIFF_W-1:0] diff_in [BBQ_AXES];
   logic [BBQ_AXES-1:0] zero_ff, zero_in;
   logic [BBQ_AXES-1:0] sat_ff, sat_in;
   logic [7:0]        flag_ff, flag_in;
   logic [7:0]        story_ff, story_in;
   logic [STEP_W-1:0] step_cnt_ff, step_cnt_in;
   logic [1:0]        emit_axis_ff, emit_axis_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [1:0]        rsp_axis_ff, rsp_axis_in;
   logic [BOX_W-1:0]  rsp_low_ff, rsp_low_in;
   logic [BOX_W-1:0]  rsp_high_ff, rsp_high_in;
   logic [QB-1:0]     rsp_quant_ff [BBQ_AXES];
   logic [QB-1:0]     rsp_quant_in [BBQ_AXES];
   logic [7:0]        rsp_flag_ff, rsp_flag_in;
   logic [7:0]        rsp_story_ff, rsp_story_in;
   logic              rsp_last_ff, rsp_last_in;

   // Divider lanes.
   bbq_div_ctl_type   div_ctl;
   logic [REM_W-1:0]  div_rem [BBQ_AXES];
   logic [NUM_W-1:0]  div_num [BBQ_AXES];
   logic [REM_W-1:0]  div_divisor [BBQ_AXES];
   logic [QUO_W-1:0]  div_quo [BBQ_AXES];

   logic signed [CW-1:0] req_coord [BBQ_AXES];
   logic [QB+1:0]     quant_round [BBQ_AXES];
   logic [QB-1:0]     quant_val [BBQ_AXES];
   logic              req_accept;
   logic              out_free;

   assign req_coord[0] = req_chan.coord_x;
   assign req_coord[1] = req_chan.coord_y;
   assign req_coord[2] = req_chan.coord_z;

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;

   // The output register can take a new result when it is empty or when its
   // current transaction completes in this cycle.
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Three divider lanes, one per axis. During a finish they divide
   // 10*dim + maxdim by 100; during a quantize they divide (p - low) *
   // 2^(QUANT_BITS+1) by the span, starting from p - low as the remainder.
   for (genvar g = 0; g < BBQ_AXES; g++) begin : g_lane
      always_comb begin
         div_num[g]     = '0;
         div_rem[g]     = '0;
         div_divisor[g] = REM_W'(BBQ_WIDEN_DIV);
         if (state_ff == S_F_NUM) begin
            div_num[g] = ten_ff[g] + NUM_W'(maxd_ff);
         end else if (state_ff == S_Q_CMP) begin
            div_rem[g]     = {1'b0, diff_ff[g][DIFF_W-2:0]};
            div_divisor[g] = {1'b0, span_ff[g]};
         end
      end

      bbq_sdiv #(
         .REM_BITS (REM_W),
         .NUM_BITS (NUM_W),
         .QUO_BITS (QUO_W)
      ) u_sdiv (
         .clock    (clock),
         .ctl      (div_ctl),
         .load_rem (div_rem[g]),
         .load_num (div_num[g]),
         .divisor  (div_divisor[g]),
         .quotient (div_quo[g])
      );

      // Round half up by adding one to the quotient that carries one extra
      // fraction bit, then saturate anything that reaches 2^QUANT_BITS.
      always_comb begin
         quant_round[g] = {1'b0, div_quo[g][QB:0]} + (QB + 2)'(1);
         if (zero_ff[g]) begin
            quant_val[g] = '0;
         end else if (sat_ff[g] || quant_round[g][QB+1]) begin
            quant_val[g] = '1;
         end else begin
            quant_val[g] = quant_round[g][QB:1];
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      have_point_in = have_point_ff;
      run_min_in    = run_min_ff;
      run_max_in    = run_max_ff;
      frozen_low_in = frozen_low_ff;
      frozen_high_in = frozen_high_ff;
      span_in       = span_ff;
      dim_in        = dim_ff;
      maxd_in       = maxd_ff;
      ten_in        = ten_ff;
      diff_in       = diff_ff;
      zero_in       = zero_ff;
      sat_in        = sat_ff;
      flag_in       = flag_ff;
      story_in      = story_ff;
      step_cnt_in   = step_cnt_ff;
      emit_axis_in  = emit_axis_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_axis_in   = rsp_axis_ff;
      rsp_low_in    = rsp_low_ff;
      rsp_high_in   = rsp_high_ff;
      rsp_quant_in  = rsp_quant_ff;
      rsp_flag_in   = rsp_flag_ff;
      rsp_story_in  = rsp_story_ff;
      rsp_last_in   = rsp_last_ff;
      div_ctl       = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               case (req_chan.req_type)
                  BBQ_REQ_ACCUM: begin
                     // The first point of a box loads both extremes.
                     for (int a = 0; a < BBQ_AXES; a++) begin
                        if (!have_point_ff || req_coord[a] < run_min_ff[a]) begin
                           run_min_in[a] = req_coord[a];
                        end
                        if (!have_point_ff || req_coord[a] > run_max_ff[a]) begin
                           run_max_in[a] = req_coord[a];
                        end
                     end
                     have_point_in = 1'b1;
                  end
                  BBQ_REQ_FINISH: begin
                     // The maximum never lies below the minimum, so the span
                     // fits the coordinate width as an unsigned value.
                     for (int a = 0; a < BBQ_AXES; a++) begin
                        dim_in[a] = run_max_ff[a] - run_min_ff[a];
                     end
                     state_in = S_F_MAX;
                  end
                  BBQ_REQ_QUANT: begin
                     for (int a = 0; a < BBQ_AXES; a++) begin
                        diff_in[a] = {{2{req_coord[a][CW-1]}}, req_coord[a]}
                                   - {frozen_low_ff[a][BOX_W-1], frozen_low_ff[a]};
                     end
                     flag_in  = req_chan.flag_in;
                     story_in = req_chan.story_in;
                     state_in = S_Q_CMP;
                  end
                  default: begin
                     // Unused request code: dropped without a result.
                  end
               endcase
            end
         end

         S_F_MAX: begin
            // Largest span of the three, and ten times each span as 8x + 2x.
            maxd_in = dim_ff[0];
            if (dim_ff[1] > maxd_in) begin
               maxd_in = dim_ff[1];
            end
            if (dim_ff[2] > maxd_in) begin
               maxd_in = dim_ff[2];
            end
            for (int a = 0; a < BBQ_AXES; a++) begin
               ten_in[a] = NUM_W'({dim_ff[a], 3'b000}) + NUM_W'({dim_ff[a], 1'b0});
            end
            state_in = S_F_NUM;
         end

         S_F_NUM: begin
            div_ctl.load = 1'b1;
            step_cnt_in  = STEP_W'(NUM_W);
            state_in     = S_F_DIV;
         end

         S_F_DIV: begin
            div_ctl.step = 1'b1;
            step_cnt_in  = step_cnt_ff - STEP_W'(1);
            if (step_cnt_ff == STEP_W'(1)) begin
               state_in = S_F_BOX;
            end
         end

         S_F_BOX: begin
            // The widening is far below 2^COORD_BITS, so its low bits suffice.
            for (int a = 0; a < BBQ_AXES; a++) begin
               frozen_low_in[a]  = {run_min_ff[a][CW-1], run_min_ff[a]}
                                 - div_quo[a][BOX_W-1:0];
               frozen_high_in[a] = {run_max_ff[a][CW-1], run_max_ff[a]}
                                 + div_quo[a][BOX_W-1:0];
            end
            have_point_in = 1'b0;
            state_in      = S_F_SPAN;
         end

         S_F_SPAN: begin
            for (int a = 0; a < BBQ_AXES; a++) begin
               span_in[a] = frozen_high_ff[a] - frozen_low_ff[a];
            end
            emit_axis_in = '0;
            state_in     = S_F_EMIT;
         end

         S_F_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = BBQ_KIND_BOX;
               rsp_axis_in  = emit_axis_ff;
               rsp_low_in   = frozen_low_ff[emit_axis_ff];
               rsp_high_in  = frozen_high_ff[emit_axis_ff];
               for (int a = 0; a < BBQ_AXES; a++) begin
                  rsp_quant_in[a] = '0;
               end
               rsp_flag_in  = '0;
               rsp_story_in = '0;
               rsp_last_in  = (emit_axis_ff == AXIS_LAST);
               if (emit_axis_ff == AXIS_LAST) begin
                  state_in = S_IDLE;
               end else begin
                  emit_axis_in = emit_axis_ff + 2'd1;
               end
            end
         end

         S_Q_CMP: begin
            // Settle the special cases; the lanes divide regardless and the
            // quotient is ignored where a special case applies.
            for (int a = 0; a < BBQ_AXES; a++) begin
               zero_in[a] = (span_ff[a] == '0) || diff_ff[a][DIFF_W-1]
                          || (diff_ff[a] == '0);
               sat_in[a]  = diff_ff[a][DIFF_W-2:0] >= span_ff[a];
            end
            div_ctl.load = 1'b1;
            step_cnt_in  = STEP_W'(QB + 1);
            state_in     = S_Q_DIV;
         end

         S_Q_DIV: begin
            div_ctl.step = 1'b1;
            step_cnt_in  = step_cnt_ff - STEP_W'(1);
            if (step_cnt_ff == STEP_W'(1)) begin
               state_in = S_Q_OUT;
            end
         end

         S_Q_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = BBQ_KIND_QUANT;
               rsp_axis_in  = '0;
               rsp_low_in   = '0;
               rsp_high_in  = '0;
               rsp_quant_in = quant_val;
               rsp_flag_in  = flag_ff;
               rsp_story_in = story_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         have_point_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int a = 0; a < BBQ_AXES; a++) begin
            run_min_ff[a]     <= '0;
            run_max_ff[a]     <= '0;
            frozen_low_ff[a]  <= '0;
            frozen_high_ff[a] <= '0;
            span_ff[a]        <= '0;
         end
      end else begin
         state_ff       <= state_in;
         have_point_ff  <= have_point_in;
         rsp_valid_ff   <= rsp_valid_in;
         run_min_ff     <= run_min_in;
         run_max_ff     <= run_max_in;
         frozen_low_ff  <= frozen_low_in;
         frozen_high_ff <= frozen_high_in;
         span_ff        <= span_in;
      end
      dim_ff       <= dim_in;
      maxd_ff      <= maxd_in;
      ten_ff       <= ten_in;
      diff_ff      <= diff_in;
      zero_ff      <= zero_in;
      sat_ff       <= sat_in;
      flag_ff      <= flag_in;
      story_ff     <= story_in;
      step_cnt_ff  <= step_cnt_in;
      emit_axis_ff <= emit_axis_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_axis_ff  <= rsp_axis_in;
      rsp_low_ff   <= rsp_low_in;
      rsp_high_ff  <= rsp_high_in;
      rsp_quant_ff <= rsp_quant_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_story_ff <= rsp_story_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_kind  = rsp_kind_ff;
   assign rsp_chan.axis      = rsp_axis_ff;
   assign rsp_chan.box_low   = rsp_low_ff;
   assign rsp_chan.box_high  = rsp_high_ff;
   assign rsp_chan.quant_x   = rsp_quant_ff[0];
   assign rsp_chan.quant_y   = rsp_quant_ff[1];
   assign rsp_chan.quant_z   = rsp_quant_ff[2];
   assign rsp_chan.flag_out  = rsp_flag_ff;
   assign rsp_chan.story_out = rsp_story_ff;
   assign rsp_chan.last      = rsp_last_ff;

   // The running extremes stay ordered once a point has been seen.
   a_run_ordered: assert property (@(posedge clock) disable iff (reset)
      have_point_ff |-> run_min_ff[0] <= run_max_ff[0] && run_min_ff[1] <= run_max_ff[1]
                        && run_min_ff[2] <= run_max_ff[2])
      else $error("running minimum above running maximum");

   // A frozen box is never inverted.
   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |->
         $signed(frozen_high_ff[0]) >= $signed(frozen_low_ff[0])
         && $signed(frozen_high_ff[1]) >= $signed(frozen_low_ff[1])
         && $signed(frozen_high_ff[2]) >= $signed(frozen_low_ff[2]))
      else $error("frozen box has high below low");

   // Only the z axis of a box closes the finish transaction sequence.
   a_box_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff == BBQ_KIND_BOX |->
         rsp_last_ff == (rsp_axis_ff == AXIS_LAST))
      else $error("box result last flag does not match its axis");

   // The divider sequencer never runs with an exhausted step count.
   a_step_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_F_DIV || state_ff == S_Q_DIV |-> step_cnt_ff != '0)
      else $error("divider running with a zero step count");

endmodule

`default_nettype wire

[tb/bbq_checker.sv]
`default_nettype none

// Watches both channels, keeps its own copy of the running box and the frozen
// box, and compares every result transaction with the oldest one predicted.
module bbq_checker
   import bbq_pkg::*;
#(
   parameter int unsigned COORD_BITS = BBQ_COORD_BITS,
   parameter int unsigned QUANT_BITS = BBQ_QUANT_BITS
) (
   input  wire logic clock,
   input  wire logic reset,
   bbq_req_if        req_mon,
   bbq_rsp_if        rsp_mon,
   output int        fail_count,
   output int        pending
);

   typedef struct {
      logic                       out_kind;
      logic [1:0]                 axis;
      logic signed [COORD_BITS:0] box_low;
      logic signed [COORD_BITS:0] box_high;
      logic [QUANT_BITS-1:0]      quant_x;
      logic [QUANT_BITS-1:0]      quant_y;
      logic [QUANT_BITS-1:0]      quant_z;
      logic [7:0]                 flag_out;
      logic [7:0]                 story_out;
      logic                       last;
   } rsp_fields_type;

   rsp_fields_type rsp_due[$];

   longint run_min [BBQ_AXES];
   longint run_max [BBQ_AXES];
   longint box_lo  [BBQ_AXES];
   longint box_hi  [BBQ_AXES];
   bit     have_point;

   // Rounded position of p within [lo, hi] on a grid of 2^QUANT_BITS steps.
   function automatic logic [QUANT_BITS-1:0] scale_to_grid(input longint p, input longint lo,
                                                            input longint hi);
      longint top;
      longint span;
      longint off;
      longint frac;
      top = (longint'(1) << QUANT_BITS) - 1;
      if (hi <= lo || p <= lo) return '0;
      span = hi - lo;
      off  = p - lo;
      if (off >= span) return top[QUANT_BITS-1:0];
      // One extra fraction bit, then round half up.
      frac = (off << (QUANT_BITS + 1)) / span;
      frac = (frac + 1) >>> 1;
      if (frac > top) frac = top;
      return frac[QUANT_BITS-1:0];
   endfunction

   task automatic forecast_results();
      longint         pt [BBQ_AXES];
      longint         span [BBQ_AXES];
      longint         widest;
      longint         widen;
      rsp_fields_type r;
      pt[0] = longint'(req_mon.coord_x);
      pt[1] = longint'(req_mon.coord_y);
      pt[2] = longint'(req_mon.coord_z);
      case (req_mon.req_type)
         BBQ_REQ_ACCUM: begin
            for (int a = 0; a < BBQ_AXES; a++) begin
               if (!have_point || pt[a] < run_min[a]) run_min[a] = pt[a];
               if (!have_point || pt[a] > run_max[a]) run_max[a] = pt[a];
            end
            have_point = 1'b1;
         end
         BBQ_REQ_FINISH: begin
            for (int a = 0; a < BBQ_AXES; a++) span[a] = run_max[a] - run_min[a];
            widest = span[0];
            if (span[1] > widest) widest = span[1];
            if (span[2] > widest) widest = span[2];
            for (int a = 0; a < BBQ_AXES; a++) begin
               widen    = (10 * span[a] + widest) / longint'(BBQ_WIDEN_DIV);
               box_lo[a] = run_min[a] - widen;
               box_hi[a] = run_max[a] + widen;
               r          = '{default: '0};
               r.out_kind = BBQ_KIND_BOX;
               r.axis     = 2'(a);
               r.box_low  = box_lo[a][COORD_BITS:0];
               r.box_high = box_hi[a][COORD_BITS:0];
               r.last     = (a == BBQ_AXES - 1);
               rsp_due.push_back(r);
            end
            have_point = 1'b0;
         end
         BBQ_REQ_QUANT: begin
            r           = '{default: '0};
            r.out_kind  = BBQ_KIND_QUANT;
            r.quant_x   = scale_to_grid(pt[0], box_lo[0], box_hi[0]);
            r.quant_y   = scale_to_grid(pt[1], box_lo[1], box_hi[1]);
            r.quant_z   = scale_to_grid(pt[2], box_lo[2], box_hi[2]);
            r.flag_out  = req_mon.flag_in;
            r.story_out = req_mon.story_in;
            r.last      = 1'b1;
            rsp_due.push_back(r);
         end
         default: ;
      endcase
   endtask

   task automatic check_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic compare_response();
      rsp_fields_type want;
      if (rsp_due.size() == 0) begin
         $error("result transaction arrived with nothing outstanding");
         fail_count++;
      end else begin
         want = rsp_due.pop_front();
         check_field("out_kind", want.out_kind, rsp_mon.out_kind);
         check_field("axis", want.axis, rsp_mon.axis);
         check_field("box_low", want.box_low, rsp_mon.box_low);
         check_field("box_high", want.box_high, rsp_mon.box_high);
         check_field("quant_x", want.quant_x, rsp_mon.quant_x);
         check_field("quant_y", want.quant_y, rsp_mon.quant_y);
         check_field("quant_z", want.quant_z, rsp_mon.quant_z);
         check_field("flag_out", want.flag_out, rsp_mon.flag_out);
         check_field("story_out", want.story_out, rsp_mon.story_out);
         check_field("last", want.last, rsp_mon.last);
      end
   endtask

   // A result can never leave on the same edge as the request that causes it,
   // so the order of the two steps below does not matter.
   always @(posedge clock) begin
      if (reset) begin
         rsp_due.delete();
         foreach (run_min[a]) begin
            run_min[a] = 0;
            run_max[a] = 0;
            box_lo[a]  = 0;
            box_hi[a]  = 0;
         end
         have_point = 1'b0;
      end else begin
         if (req_mon.valid && req_mon.ready) forecast_results();
         if (rsp_mon.valid && rsp_mon.ready) compare_response();
      end
      pending = rsp_due.size();
   end

endmodule

`default_nettype wire

[tb/tb_top.sv]
`default_nettype none

// Top of the testbench for the bounding-box point quantizer. It produces the
// request transactions, plays the part of the result receiver and gives the
// verdict; all prediction and comparison lives in the checker beside the block.
module tb_top
   import bbq_pkg::*;
();

   // Request code that the block drops without any result.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic signed [31:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;

   // Length of the deliberate receiver hold-off, in clock cycles.
   localparam int LONG_HOLD = 400;

   logic clock = 1'b0;
   logic reset;

   // When quiet is set, neither side inserts random idle cycles.
   bit quiet           = 1'b0;
   // Asks the receiver process to hold ready low for the long hold-off.
   bit want_long_stall = 1'b0;

   int fail_count;
   int rsp_pending;
   int items_sent;

   // Shape of the current random box session: 0 tight, 1 medium, 2 full range.
   int unsigned            scale;
   int unsigned            spread;
   logic signed [31:0]     centre [BBQ_AXES];

   bbq_req_if req_chan ();
   bbq_rsp_if rsp_chan ();

   bounding_box_point_quantizer_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   bbq_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (rsp_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Offers one request transaction and returns on the edge at which it is
   // taken. Valid is left high, so that a following call either keeps it high
   // or lowers it for an idle cycle, never both within one time step. The
   // caller is always positioned just after a rising edge.
   task automatic send_req(input logic [1:0] code, input logic [31:0] x, input logic [31:0] y,
                           input logic [31:0] z, input logic [7:0] flag, input logic [7:0] story);
      if (!quiet) begin
         while ($urandom_range(99) < 12) begin
            req_chan.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= code;
      req_chan.coord_x  <= x;
      req_chan.coord_y  <= y;
      req_chan.coord_z  <= z;
      req_chan.flag_in  <= flag;
      req_chan.story_in <= story;
      do @(posedge clock); while (!req_chan.ready);
      if (code != REQ_UNUSED) items_sent++;
   endtask

   // Stops offering and waits until every predicted result has been taken.
   // Waiting for the falling edge keeps the test of the outstanding count clear
   // of the edge on which the checker updates it.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      wait (rsp_pending == 0);
      @(posedge clock);
   endtask

   // A coordinate close to the session's centre on one axis. Quantize points
   // use a wider scatter so that a fair share fall outside the frozen box, and
   // now and then a point is drawn from the whole range.
   function automatic logic [31:0] pick_coord(input int axis, input bit scatter);
      longint      v;
      int unsigned reach;
      if (scale == 2 || (scatter && $urandom_range(9) == 0)) return $urandom;
      reach = scatter ? spread + spread / 2 : spread;
      v = longint'(centre[axis]) + longint'($urandom_range(2 * reach)) - longint'(reach);
      if (v > longint'(C_MAX)) v = longint'(C_MAX);
      if (v < longint'(C_MIN)) v = longint'(C_MIN);
      return v[31:0];
   endfunction

   task automatic send_point(input logic [1:0] code, input bit scatter);
      send_req(code, pick_coord(0, scatter), pick_coord(1, scatter), pick_coord(2, scatter),
               8'($urandom), 8'($urandom));
   endtask

   // Receiver: random back-pressure, switched off while quiet is set, plus one
   // long hold-off on request, counted here in clock cycles.
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (want_long_stall) begin
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            want_long_stall = 1'b0;
         end
         rsp_chan.ready <= quiet || ($urandom_range(99) >= 12);
      end
   end

   // Guard against a hung handshake: far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int session;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= BBQ_REQ_ACCUM;
      req_chan.coord_x  <= '0;
      req_chan.coord_y  <= '0;
      req_chan.coord_z  <= '0;
      req_chan.flag_in  <= '0;
      req_chan.story_in <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Quantizing before any finish sees a flat box, so every
      // axis must give zero; a finish with no point after reset freezes an
      // all-zero box.
      send_req(BBQ_REQ_QUANT, 32'd123, -32'sd456, 32'd0, 8'hFF, 8'h00);
      send_req(BBQ_REQ_FINISH, '0, '0, '0, 8'h00, 8'h00);
      send_req(BBQ_REQ_QUANT, '0, '0, '0, 8'h00, 8'hFF);

      // The widest possible box, with the coordinate extremes quantized in it.
      send_req(BBQ_REQ_ACCUM, C_MIN, C_MIN, C_MIN, 8'h00, 8'h00);
      send_req(BBQ_REQ_ACCUM, C_MAX, C_MAX, C_MAX, 8'hFF, 8'hFF);
      send_req(BBQ_REQ_ACCUM, 32'd0, -32'sd1, 32'd1, 8'h5A, 8'hA5);
      send_req(BBQ_REQ_FINISH, '0, '0, '0, 8'h00, 8'h00);
      send_req(BBQ_REQ_QUANT, C_MIN, 32'd0, C_MAX, 8'h00, 8'hFF);
      send_req(BBQ_REQ_QUANT, C_MAX, C_MIN, -32'sd1, 8'hFF, 8'h00);

      // A second finish with no point in between rebuilds the same box from
      // the extremes that are still held.
      send_req(BBQ_REQ_FINISH, '0, '0, '0, 8'h00, 8'h00);

      // A single point gives a zero span on every axis.
      send_req(BBQ_REQ_ACCUM, 32'd5, -32'sd7, 32'd100, 8'h00, 8'h00);
      send_req(BBQ_REQ_FINISH, '0, '0, '0, 8'h00, 8'h00);
      send_req(BBQ_REQ_QUANT, 32'd5, -32'sd7, 32'd100, 8'h81, 8'h18);

      // Flat y only; points inside, below and above the box on the other axes.
      send_req(BBQ_REQ_ACCUM, 32'd0, 32'd3, 32'd0, 8'h00, 8'h00);
      send_req(BBQ_REQ_ACCUM, 32'd1000, 32'd3, -32'sd50, 8'h00, 8'h00);
      send_req(BBQ_REQ_FINISH, '0, '0, '0, 8'h00, 8'h00);
      send_req(BBQ_REQ_QUANT, 32'd500, 32'd3, -32'sd25, 8'h01, 8'h80);
      send_req(BBQ_REQ_QUANT, -32'sd100, 32'd3, -32'sd1000, 8'h7F, 8'hFE);
      send_req(BBQ_REQ_QUANT, 32'd2000, 32'd3, 32'd50, 8'hC3, 8'h3C);

      // The unused request code must vanish without a result.
      send_req(REQ_UNUSED, C_MAX, C_MIN, C_MAX, 8'hFF, 8'hFF);

      // A symmetric box whose centre lands exactly on a grid step.
      send_req(BBQ_REQ_ACCUM, -32'sd1, -32'sd1, -32'sd1, 8'h00, 8'h00);
      send_req(BBQ_REQ_ACCUM, 32'd1, 32'd1, 32'd1, 8'h00, 8'h00);
      send_req(BBQ_REQ_FINISH, '0, '0, '0, 8'h00, 8'h00);
      send_req(BBQ_REQ_QUANT, '0, '0, '0, 8'h33, 8'hCC);
      drain();

      // Random part: mostly well-formed sessions of accumulate, finish and
      // quantize with random content, salted with finishes on an empty box,
      // quantizes against a stale box and dropped request codes.
      session    = 0;
      while (items_sent < 120) begin
         session++;
         quiet = (session >= 6 && session <= 9);
         scale = $urandom_range(2);
         spread = (scale == 0) ? $urandom_range(1, 1000) : $urandom_range(1, 1 << 20);
         foreach (centre[a]) centre[a] = $urandom;

         if (session == 12) drain();

         if ($urandom_range(9) != 0) begin
            repeat ($urandom_range(1, 6)) send_point(BBQ_REQ_ACCUM, 1'b0);
         end
         if ($urandom_range(11) == 0) send_point(BBQ_REQ_QUANT, 1'b1);
         if ($urandom_range(15) == 0) send_point(REQ_UNUSED, 1'b1);
         send_point(BBQ_REQ_FINISH, 1'b0);
         repeat ($urandom_range(1, 8)) send_point(BBQ_REQ_QUANT, 1'b1);

         // Hold the receiver off while quantize transactions keep coming, so
         // that the output register fills and the request side backs up.
         if (session == 3) begin
            want_long_stall = 1'b1;
            repeat (8) send_point(BBQ_REQ_QUANT, 1'b1);
         end
      end
      quiet = 1'b0;
      drain();

      // A short settling period catches any stray result after the last one.
      repeat (80) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
